### rtl/core/sfd_pkg.sv
// Shared phase, status and register-index codes for the serial frame deframer.
`default_nettype none

package sfd_pkg;

   // Parse phase codes.
   localparam logic [2:0] PH_HUNT1   = 3'd0;
   localparam logic [2:0] PH_HUNT2   = 3'd1;
   localparam logic [2:0] PH_TYPE    = 3'd2;
   localparam logic [2:0] PH_LEN1    = 3'd3;
   localparam logic [2:0] PH_LEN2    = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_CHECK   = 3'd6;

   // Result status codes.
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_BYTE    = 3'd1;
   localparam logic [2:0] ST_GOOD    = 3'd2;
   localparam logic [2:0] ST_TIMEOUT = 3'd3;
   localparam logic [2:0] ST_BADSUM  = 3'd4;

   // Request kinds.
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_HEADER_FIRST  = 2'd0;
   localparam logic [1:0] CSR_HEADER_SECOND = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT_MS    = 2'd2;
   localparam logic [1:0] CSR_MAX_PAYLOAD   = 2'd3;

   // Register reset values.
   localparam logic [7:0]  HEADER_FIRST_RST  = 8'hAA;
   localparam logic [7:0]  HEADER_SECOND_RST = 8'h55;
   localparam logic [15:0] TIMEOUT_MS_RST    = 16'd100;
   localparam logic [13:0] MAX_PAYLOAD_RST   = 14'd256;

   // Length byte fields.
   localparam logic [7:0] LOW7_MASK = 8'h7F;
   localparam logic [7:0] CONT_BIT  = 8'h80;

   // One result as it sits in the output register.
   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  frame_type;
      logic [13:0] payload_length;
      logic [7:0]  payload_byte;
      logic [13:0] payload_index;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/core/serial_frame_deframer_unit.sv
// Serial frame deframer top level: header hunt, length decode, payload, checksum, timeout.
// An accepted request's response is registered in the output register at the next clock edge.
// Throughput: one request per cycle; the only limit is the single output register,
// which takes a new response in the same cycle the held one is taken.
// Reset (synchronous, active high): parser hunts for the first header byte, all
// frame state is zero, registers return to 0xAA, 0x55, 100 ms and 256 bytes.
`default_nettype none

module serial_frame_deframer_unit
   import sfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic        req_type,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic [15:0] req_elapsed_ms,

   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [7:0]  rsp_frame_type,
   output      logic [13:0] rsp_payload_length,
   output      logic [7:0]  rsp_payload_byte,
   output      logic [13:0] rsp_payload_index,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [7:0]  header_first_ff;
   logic [7:0]  header_second_ff;
   logic [15:0] timeout_ms_ff;
   logic [13:0] max_payload_ff;

   // Parser state.
   logic [2:0]  phase_ff,     phase_in;
   logic [7:0]  type_ff,      type_in;
   logic [13:0] length_ff,    length_in;
   logic [13:0] position_ff,  position_in;
   logic [7:0]  sum_ff,       sum_in;
   logic [16:0] idle_ff,      idle_in;

   // Output register.
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   rsp_type     rsp_in;

   logic        req_fire;
   logic [13:0] new_length;
   logic [13:0] position_inc;
   logic [7:0]  sum_add;
   logic [7:0]  sum_inv;
   logic [16:0] idle_add;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_first_ff  <= HEADER_FIRST_RST;
         header_second_ff <= HEADER_SECOND_RST;
         timeout_ms_ff    <= TIMEOUT_MS_RST;
         max_payload_ff   <= MAX_PAYLOAD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HEADER_FIRST:  header_first_ff  <= csr_wdata[7:0];
            CSR_HEADER_SECOND: header_second_ff <= csr_wdata[7:0];
            CSR_TIMEOUT_MS:    timeout_ms_ff    <= csr_wdata;
            CSR_MAX_PAYLOAD:   max_payload_ff   <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   // Shared arithmetic for the parse step.
   assign sum_add      = sum_ff + req_rx_byte;
   assign sum_inv      = ~sum_ff;
   assign position_inc = position_ff + 14'd1;
   assign idle_add     = idle_ff + {1'b0, req_elapsed_ms};
   assign new_length   = (phase_ff == PH_LEN2) ? {req_rx_byte[6:0], length_ff[6:0]}
                                               : {6'd0, req_rx_byte & LOW7_MASK};

   // One parse step per request: next state and the response.
   always_comb begin
      phase_in    = phase_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      position_in = position_ff;
      sum_in      = sum_ff;
      idle_in     = idle_ff;
      rsp_in      = '0;
      rsp_in.status = ST_NONE;

      if (req_type == REQ_BYTE) begin
         idle_in = '0;
         case (phase_ff)
            PH_HUNT1: begin
               if (req_rx_byte == header_first_ff) phase_in = PH_HUNT2;
            end
            PH_HUNT2: begin
               // A repeated first header byte keeps waiting for the second one.
               if (req_rx_byte == header_second_ff) phase_in = PH_TYPE;
               else if (req_rx_byte != header_first_ff) phase_in = PH_HUNT1;
            end
            PH_TYPE: begin
               type_in     = req_rx_byte;
               sum_in      = req_rx_byte;
               position_in = '0;
               phase_in    = PH_LEN1;
            end
            PH_LEN1, PH_LEN2: begin
               sum_in = sum_add;
               if ((req_rx_byte & CONT_BIT) != 8'd0) begin
                  if (phase_ff == PH_LEN1) begin
                     length_in = new_length;
                     phase_in  = PH_LEN2;
                  end else begin
                     // A third length group abandons the frame.
                     phase_in = (req_rx_byte == header_first_ff) ? PH_HUNT2 : PH_HUNT1;
                  end
               end else begin
                  length_in = new_length;
                  if (new_length > max_payload_ff) phase_in = PH_HUNT1;
                  else if (new_length == 14'd0)    phase_in = PH_CHECK;
                  else                             phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               rsp_in.status        = ST_BYTE;
               rsp_in.payload_byte  = req_rx_byte;
               rsp_in.payload_index = position_ff;
               sum_in      = sum_add;
               position_in = position_inc;
               if (position_inc >= length_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               sum_in        = sum_inv;
               phase_in      = PH_HUNT1;
               rsp_in.status = (sum_inv == req_rx_byte) ? ST_GOOD : ST_BADSUM;
            end
            default: begin
               phase_in = (req_rx_byte == header_first_ff) ? PH_HUNT2 : PH_HUNT1;
            end
         endcase
      end else if (phase_ff != PH_HUNT1) begin
         // Ticks only count while the parser is not hunting for the first header byte.
         idle_in = idle_add;
         if (idle_add > {1'b0, timeout_ms_ff}) begin
            phase_in      = PH_HUNT1;
            idle_in       = '0;
            rsp_in.status = ST_TIMEOUT;
         end
      end

      rsp_in.frame_type     = type_in;
      rsp_in.payload_length = length_in;
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT1;
         type_ff     <= '0;
         length_ff   <= '0;
         position_ff <= '0;
         sum_ff      <= '0;
         idle_ff     <= '0;
      end else if (req_fire) begin
         phase_ff    <= phase_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         position_ff <= position_in;
         sum_ff      <= sum_in;
         idle_ff     <= idle_in;
      end
   end

   // Output register: loads whenever a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_frame_type     = rsp_ff.frame_type;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_payload_index  = rsp_ff.payload_index;

`ifndef SYNTHESIS
   // Every accepted request leaves a response behind.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // While hunting for the first header byte, no idle time is carried.
   a_hunt_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT1) |-> (idle_ff == 17'd0))
      else $error("idle time left over while hunting");

   // A payload byte always lies inside the decoded length.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_BYTE) |->
         (rsp_ff.payload_index < rsp_ff.payload_length))
      else $error("payload index beyond frame length");

   // Byte fields are zero unless a payload byte is reported.
   a_byte_fields_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != ST_BYTE) |->
         (rsp_ff.payload_byte == 8'd0 && rsp_ff.payload_index == 14'd0))
      else $error("payload fields set on a non-byte response");
`endif

endmodule

`default_nettype wire
